// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, disabled while reset is asserted.
`define WPCRF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define WPCRF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WPCRF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/wpcrf_pkg.sv
// ----------------------------------------------------------------------------
// wpcrf_pkg
// Types, constants and helpers for the windowed pitch-class root finder.
// ----------------------------------------------------------------------------
package wpcrf_pkg;

	localparam int WINDOW_DEPTH = 64;
	localparam int NUM_CLASSES  = 12;
	localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int CLS_W        = 4;
	localparam int PITCH_W      = 7;
	localparam int FIELD_W      = 7;
	localparam int TIME_W       = 32;
	localparam int WIN_W        = 16;

	localparam logic [WIN_W-1:0] WINDOW_MS_RESET = 16'd4000;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CLS_W-1:0] cls_t;

	typedef struct packed {
		logic [PITCH_W-1:0] pitch;
		logic [TIME_W-1:0]  time_ms;
	} note_t;

	typedef struct packed {
		logic [CLS_W-1:0]   root_class;
		logic [FIELD_W-1:0] root_count;
		logic [FIELD_W-1:0] window_notes;
		logic [PITCH_W-1:0] last_pitch;
	} result_t;

	typedef struct packed {
		cls_t              cls;
		logic [TIME_W-1:0] time_ms;
	} entry_t;

	// counter bank control
	typedef struct packed {
		logic inc;
		cls_t inc_cls;
		logic dec;
		cls_t dec_cls;
		cls_t scan_idx;
	} bank_ctrl_t;

	// pitch mod 12 via reciprocal: q = (p * 43) >> 9 is exact for p < 128
	function automatic cls_t pitch_class(input logic [PITCH_W-1:0] p);
		logic [12:0]        prod;
		logic [3:0]         q;
		logic [PITCH_W-1:0] r;
		prod = 13'(p) * 13'd43;
		q    = prod[12:9];
		r    = p - (7'(q) * 7'd12);
		return r[CLS_W-1:0];
	endfunction

endpackage

// File: hw/rtl/wpcrf_class_bank.sv
// ----------------------------------------------------------------------------
// wpcrf_class_bank
// Twelve pitch-class counters with one increment, one decrement and a scan
// read port for the argmax sweep.
// ----------------------------------------------------------------------------
module wpcrf_class_bank (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wpcrf_pkg::bank_ctrl_t ctrl,
	output wpcrf_pkg::cnt_t       scan_count
);
	import wpcrf_pkg::*;

	cnt_t counts_q [NUM_CLASSES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) counts_q[i] <= '0;
		end else begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				if (ctrl.inc && ctrl.inc_cls == CLS_W'(i)) begin
					counts_q[i] <= counts_q[i] + 1'b1;
				end else if (ctrl.dec && ctrl.dec_cls == CLS_W'(i) && counts_q[i] != '0) begin
					counts_q[i] <= counts_q[i] - 1'b1;
				end
			end
		end
	end

	assign scan_count = (ctrl.scan_idx < CLS_W'(NUM_CLASSES)) ? counts_q[ctrl.scan_idx] : '0;

endmodule

// File: hw/rtl/windowed_pitch_class_root_finder_unit.sv
// ----------------------------------------------------------------------------
// windowed_pitch_class_root_finder_unit
// Sliding-window pitch-class histogram over a ring of recent note-ons,
// reporting the most frequent class per accepted note.
// ----------------------------------------------------------------------------
// Per note: drop the oldest entry if the ring is full on entry, append the new
// note, then read, age-check and evict aged entries one at a time, then sweep.
// A new note is taken only when idle; the work per note is set by the single
// read port of the ring memory (read, compare, evict loop) and the 12-step sweep.
// Reset (arst_n, async low): ring empty, counters zero, window_ms = 4000.
// The result sits in an output register, so the next note is taken meanwhile.
// ----------------------------------------------------------------------------
module windowed_pitch_class_root_finder_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [wpcrf_pkg::WIN_W-1:0] cfg_data,
	// note input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  wpcrf_pkg::note_t            in_data,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output wpcrf_pkg::result_t          out_data
);
	import wpcrf_pkg::*;

	// Sequencer: one-hot.
	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_DROP_RD = 7'b0000010, // ring full: wait for oldest entry read
		ST_DROP    = 7'b0000100, // drop oldest before append
		ST_APPEND  = 7'b0001000, // write new note, bump its counter
		ST_EV_RD   = 7'b0010000, // wait for oldest entry read
		ST_EV_CHK  = 7'b0100000, // age check, evict or move on
		ST_SCAN    = 7'b1000000  // argmax over counters, then publish
	} state_t;

	state_t state_q, state_d;

	// Window register: always writable; config must only arrive while idle (the block does not enforce it).
	logic [WIN_W-1:0] window_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_MS_RESET;
		end else if (cfg_valid) begin
			window_q <= cfg_data;
		end
	end

	// Ring pointers
	ptr_t oldest_q;
	cnt_t fill_q;

	// Latched note
	logic [PITCH_W-1:0] pitch_q;
	logic [TIME_W-1:0]  time_q;
	cls_t               cls_q;

	// Argmax sweep
	cls_t scan_idx_q;
	cls_t best_cls_q;
	cnt_t best_cnt_q;
	cnt_t scan_count;

	// Ring memory: class and timestamp per slot, registered read of the
	// oldest slot every cycle. Writes only happen in ST_APPEND and the read
	// that is used next is taken in ST_EV_RD, the state after it, so no bypass is needed.
	entry_t ring_mem [WINDOW_DEPTH];
	entry_t ring_rd_q;
	logic   wr_en;
	ptr_t   wr_addr;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= '{cls: cls_q, time_ms: time_q};
		end
		ring_rd_q <= ring_mem[oldest_q];
	end

	// Append slot = (oldest + fill) mod depth
	logic [CNT_W:0] slot_sum;
	logic [CNT_W:0] slot_mod;

	assign slot_sum = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(fill_q);
	assign slot_mod = (slot_sum >= (CNT_W+1)'(WINDOW_DEPTH))
		? slot_sum - (CNT_W+1)'(WINDOW_DEPTH) : slot_sum;
	assign wr_addr  = slot_mod[PTR_W-1:0];
	assign wr_en    = (state_q == ST_APPEND);

	ptr_t oldest_inc;
	assign oldest_inc = (oldest_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

	// Signed age of oldest note; negative never evicts.
	logic [TIME_W:0] age;
	logic            evict;

	assign age   = {1'b0, time_q} - {1'b0, ring_rd_q.time_ms};
	assign evict = !age[TIME_W] && (age[TIME_W-1:0] > TIME_W'(window_q)) && (fill_q != '0);

	logic ring_full;
	assign ring_full = (fill_q == CNT_W'(WINDOW_DEPTH));

	// Output register
	logic    out_valid_q;
	result_t out_q;
	logic    out_load;
	logic    scan_last;

	assign scan_last = (scan_idx_q == CLS_W'(NUM_CLASSES - 1));
	assign out_load  = (state_q == ST_SCAN) && scan_last && (!out_valid_q || out_ready);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Counter bank
	bank_ctrl_t bank_ctrl;

	always_comb begin
		bank_ctrl          = '0;
		bank_ctrl.inc      = (state_q == ST_APPEND);
		bank_ctrl.inc_cls  = cls_q;
		bank_ctrl.dec      = (state_q == ST_DROP) || ((state_q == ST_EV_CHK) && evict);
		bank_ctrl.dec_cls  = ring_rd_q.cls;
		bank_ctrl.scan_idx = scan_idx_q;
	end

	wpcrf_class_bank u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (bank_ctrl),
		.scan_count (scan_count)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ring_full ? ST_DROP_RD : ST_APPEND;
			end
			ST_DROP_RD: state_d = ST_DROP;
			ST_DROP:    state_d = ST_APPEND;
			ST_APPEND:  state_d = ST_EV_RD;
			ST_EV_RD:   state_d = ST_EV_CHK;
			ST_EV_CHK: begin
				state_d = evict ? ST_EV_RD : ST_SCAN;
			end
			ST_SCAN: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			oldest_q <= '0;
			fill_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_DROP) || ((state_q == ST_EV_CHK) && evict)) begin
				oldest_q <= oldest_inc;
				fill_q   <= fill_q - 1'b1;
			end else if (state_q == ST_APPEND) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Note latch and sweep registers: payload, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pitch_q <= in_data.pitch;
			time_q  <= in_data.time_ms;
			cls_q   <= pitch_class(in_data.pitch);
		end
		if ((state_q == ST_EV_CHK) && !evict) begin
			scan_idx_q <= '0;
			best_cls_q <= '0;
			best_cnt_q <= '0;
		end else if (state_q == ST_SCAN && !scan_last) begin
			scan_idx_q <= scan_idx_q + 1'b1;
			if (scan_count > best_cnt_q) begin
				best_cnt_q <= scan_count;
				best_cls_q <= scan_idx_q;
			end
		end
	end

	// Last sweep step folds into the published result.
	cls_t final_cls;
	cnt_t final_cnt;

	assign final_cls = (scan_count > best_cnt_q) ? scan_idx_q : best_cls_q;
	assign final_cnt = (scan_count > best_cnt_q) ? scan_count : best_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.root_class   <= final_cls;
			out_q.root_count   <= FIELD_W'(final_cnt);
			out_q.window_notes <= FIELD_W'(fill_q);
			out_q.last_pitch   <= pitch_q;
		end
	end

endmodule

// File: hw/rtl/wpcrf_checker.sv
// ----------------------------------------------------------------------------
// wpcrf_checker
// Port-level checks of the root finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpcrf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input wpcrf_pkg::note_t   in_data,
	input logic               out_valid,
	input logic               out_ready,
	input wpcrf_pkg::result_t out_data
);
	import wpcrf_pkg::*;

	`WPCRF_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data), "result changed while stalled")
	`WPCRF_ASSERT_NXT(a_in_hold, clk, arst_n, in_valid && !in_ready,
		in_valid && $stable(in_data), "note changed while waiting")
	`WPCRF_ASSERT_NXT(a_busy_after_in, clk, arst_n, in_valid && in_ready,
		!in_ready, "input taken while a note is in work")
	`WPCRF_ASSERT_IMP(a_class_range, clk, arst_n, out_valid,
		out_data.root_class <= CLS_W'(NUM_CLASSES - 1), "root class out of range")
	`WPCRF_ASSERT_IMP(a_count_le_notes, clk, arst_n, out_valid,
		(WINDOW_DEPTH >= 128) || ((out_data.root_count != '0) &&
		(out_data.root_count <= out_data.window_notes)), "root count inconsistent with window")

endmodule

bind windowed_pitch_class_root_finder_unit wpcrf_checker u_wpcrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
